// ===== rtl/vosc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the VOSIM oscillator: sizes, register codes, sequencer states
// and the sine-squared table function. No dependencies.
package vosc_pkg;

    localparam int CHANNELS_DEF   = 16;
    localparam int TABLE_SIZE_DEF = 512;

    localparam int CH_FIELD_W = 4;
    localparam int HZ_W       = 24;
    localparam int OUT_W      = 16;
    localparam int SP_W       = 32;
    localparam int GAIN_W     = 17;
    localparam int PHASE_W    = 34;
    localparam int RES_W      = 32;
    localparam int INC_W      = 33;
    localparam int ROM_W      = 31;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;
    localparam logic [63:0]       PI_Q30   = 64'd3373259426;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd0;
    localparam logic [1:0] REG_DECAY_GAIN    = 2'd1;
    localparam logic [1:0] REG_DUTY_LIMIT    = 2'd2;

    // input commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_RESET  = 1'b1;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_FETCH, S_MULC, S_BRANCH, S_DIVR, S_LIM, S_GAIN,
        S_DIVF, S_GMUL, S_GSET, S_POS, S_IDX, S_RD1, S_RD2, S_INTERP,
        S_VAL, S_OMUL, S_WB
    } t_state;

    // divider request
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [32:0] divisor;
    } t_div_req;

    // sin(x)^2 in Q1.30 for x in Q2.30, Taylor series to x^13
    function automatic logic [ROM_W-1:0] sinsq(input logic [63:0] x);
        logic [63:0]        term;
        logic signed [65:0] sum;
        logic [63:0]        s;
        logic [63:0]        sq;
        term = x;
        sum  = $signed({2'b00, x});
        for (int k = 1; k <= 6; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) begin
                sum = sum - $signed({2'b00, term});
            end else begin
                sum = sum + $signed({2'b00, term});
            end
        end
        if (sum < 0) begin
            s = 64'd0;
        end else if (sum > 66'sd1073741824) begin
            s = 64'd1073741824;
        end else begin
            s = 64'(sum);
        end
        sq = (s * s) >> 30;
        return sq[ROM_W-1:0];
    endfunction

endpackage

// ===== rtl/vosc_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the VOSIM oscillator: valid/ready plus one sample request.
// Depends on vosc_pkg.
interface vosc_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  command;
    logic [vosc_pkg::CH_FIELD_W-1:0]       channel;
    logic signed [vosc_pkg::HZ_W-1:0]      fund_hz;
    logic signed [vosc_pkg::HZ_W-1:0]      center_hz;

    modport source (output valid, command, channel, fund_hz, center_hz, input ready);
    modport sink   (input valid, command, channel, fund_hz, center_hz, output ready);
endinterface

// ===== rtl/vosc_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the VOSIM oscillator: valid/ready plus one sample.
// Depends on vosc_pkg.
interface vosc_out_if;
    logic                              valid;
    logic                              ready;
    logic [vosc_pkg::CH_FIELD_W-1:0]   out_channel;
    logic [vosc_pkg::OUT_W-1:0]        sample_out;

    modport source (output valid, out_channel, sample_out, input ready);
    modport sink   (input valid, out_channel, sample_out, output ready);
endinterface

// ===== rtl/vosc_div.sv =====
`timescale 1ns / 1ps
// Restoring radix-2 divider, 64-bit dividend by 33-bit divisor, one bit per
// cycle. Depends on vosc_pkg.
module vosc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vosc_pkg::t_div_req  i_req,
    output logic                o_done,
    output logic [63:0]         o_quot
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [5:0]  r_cnt, n_cnt;
    logic [33:0] r_rem, n_rem;
    logic [63:0] r_dvd, n_dvd;
    logic [32:0] r_dsr, n_dsr;
    logic [33:0] trial;
    logic        fits;

    // one quotient bit: shift in, compare, subtract
    assign trial = {r_rem[32:0], r_dvd[63]};
    assign fits  = (trial >= {1'b0, r_dsr});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvd  = i_req.dividend;
            n_dsr  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = fits ? (trial - {1'b0, r_dsr}) : trial;
            n_dvd = {r_dvd[62:0], fits};
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule

// ===== rtl/vosc_rom.sv =====
`timescale 1ns / 1ps
// Constant sine-squared table, Q1.30, symmetric over one half period.
// Depends on vosc_pkg.
module vosc_rom #(
    parameter int TABLE_SIZE = vosc_pkg::TABLE_SIZE_DEF
) (
    input  logic [$clog2(TABLE_SIZE)-1:0]  i_addr,
    output logic [vosc_pkg::ROM_W-1:0]     o_data
);

    logic [vosc_pkg::ROM_W-1:0] tbl [TABLE_SIZE];

    // fold the index, scale to x in [0, pi/2], square the sine
    for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_entry
        localparam int          FOLD = (i < TABLE_SIZE - 1 - i) ? i : TABLE_SIZE - 1 - i;
        localparam logic [63:0] X    = (vosc_pkg::PI_Q30 * 64'(FOLD)) / 64'(TABLE_SIZE - 1);
        assign tbl[i] = vosc_pkg::sinsq(X);
    end

    assign o_data = tbl[i_addr];

endmodule

// ===== rtl/vosim_oscillator.sv =====
`timescale 1ns / 1ps
// VOSIM oscillator top: sequencer around one shared 34x32 multiplier and an
// iterative divider. Without a pulse wrap no divide runs; on a pulse wrap
// the ratio divide runs unless the centre increment is zero, and the fade
// divide follows when the pulse limit is positive and the ratio nonzero.
// One item at a time; ready only in idle, which is re-entered when the
// result is loaded into the output register. A reset command sweeps the
// channel state. After i_rst_n (synchronous, active low) a clearing
// pass zeroes the channel memory before the first item.
module vosim_oscillator #(
    parameter int CHANNELS   = vosc_pkg::CHANNELS_DEF,
    parameter int TABLE_SIZE = vosc_pkg::TABLE_SIZE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    vosc_in_if.sink                        i_in,
    vosc_out_if.source                     o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vosc_pkg::ADDR_W-1:0]    paddr,
    input  logic [vosc_pkg::DATA_W-1:0]    pwdata,
    output logic [vosc_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TW    = $clog2(TABLE_SIZE);
    localparam int PW    = vosc_pkg::PHASE_W;
    localparam int GW    = vosc_pkg::GAIN_W;
    localparam int RW    = vosc_pkg::RES_W;
    localparam int IW    = vosc_pkg::INC_W;
    localparam int VW    = vosc_pkg::ROM_W;
    localparam int MEM_W = 2 * PW + RW + GW;
    localparam logic [TW-1:0] TOP_IDX = TW'(TABLE_SIZE - 1);

    // configuration registers
    logic [vosc_pkg::SP_W-1:0] r_sp;
    logic [GW-1:0]             r_decay;
    logic [GW-1:0]             r_duty;

    // sequencer
    vosc_pkg::t_state r_state, n_state;
    logic [CH_W-1:0]  r_clr_cnt;
    logic             r_clr_one;

    // item and channel working registers
    logic [vosc_pkg::CH_FIELD_W-1:0] r_ch;
    logic [22:0]      r_f, r_c;
    logic [IW-1:0]    r_finc, r_cinc;
    logic [PW-1:0]    r_fp, r_pp;
    logic [RW-1:0]    r_res;
    logic [GW-1:0]    r_dec, r_g, r_fade;
    logic [31:0]      r_ratio;
    logic signed [36:0] r_lim;
    logic [TW-1:0]    r_addr;
    logic [31:0]      r_frac;
    logic [VW-1:0]    r_v1, r_v2, r_val;
    logic [MEM_W-1:0] r_mem_q;

    // output register
    logic                            r_ovalid;
    logic [vosc_pkg::CH_FIELD_W-1:0] r_och;
    logic [vosc_pkg::OUT_W-1:0]      r_osample;

    // shared multiplier
    logic [33:0] mul_a;
    logic [31:0] mul_b;
    logic [65:0] r_prod;

    // channel memory
    logic [MEM_W-1:0] mem [CHANNELS];
    logic             mem_we;
    logic [CH_W-1:0]  mem_waddr;
    logic [MEM_W-1:0] mem_wdata;

    // divider and table
    vosc_pkg::t_div_req div_req;
    logic               div_done;
    logic [63:0]        div_quot;
    logic [VW-1:0]      rom_data;

    // misc combinational
    logic [22:0]      in_f, in_c;
    logic             in_ch_ok;
    logic [IW-1:0]    sat_inc;
    logic signed [36:0] lim_calc;
    logic signed [36:0] lim_a, lim_b, lim_m;
    logic [PW-1:0]    fp_wrapped;
    logic [13:0]      pos_hi;
    logic [TW-1:0]    idx_clamped;
    logic [VW-1:0]    v_diff;
    logic [33:0]      step;
    logic             out_free;
    logic             cfg_we;

    vosc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    vosc_rom #(.TABLE_SIZE(TABLE_SIZE)) u_rom (
        .i_addr (r_addr),
        .o_data (rom_data)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp    <= '0;
            r_decay <= '0;
            r_duty  <= vosc_pkg::GAIN_ONE;
        end else if (cfg_we) begin
            case (paddr[3:2])
                vosc_pkg::REG_SAMPLE_PERIOD: r_sp    <= pwdata;
                vosc_pkg::REG_DECAY_GAIN:    r_decay <= pwdata[GW-1:0];
                vosc_pkg::REG_DUTY_LIMIT:    r_duty  <= pwdata[GW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            vosc_pkg::REG_SAMPLE_PERIOD: prdata = r_sp;
            vosc_pkg::REG_DECAY_GAIN:    prdata = 32'(r_decay);
            vosc_pkg::REG_DUTY_LIMIT:    prdata = 32'(r_duty);
            default:                     prdata = '0;
        endcase
    end

    // clamp the frequencies: fundamental at zero, centre at the fundamental
    assign in_f = i_in.fund_hz[23] ? 23'd0 : i_in.fund_hz[22:0];
    assign in_c = (i_in.center_hz < $signed({1'b0, in_f})) ? in_f : i_in.center_hz[22:0];
    assign in_ch_ok = (32'(i_in.channel) < 32'(CHANNELS));

    // increment from the last product, capped at one
    assign sat_inc = (r_prod[65:8] > 58'h100000000) ? 33'h100000000 : r_prod[40:8];

    // pulse length limit: min(1 - 2*ratio, duty) - phase + residue
    assign lim_a    = (37'sd1 <<< 32) - $signed(37'({r_ratio, 1'b0}));
    assign lim_b    = $signed(37'({r_duty, 16'h0000}));
    assign lim_m    = (lim_b < lim_a) ? lim_b : lim_a;
    assign lim_calc = lim_m - $signed(37'(r_fp)) + $signed(37'(r_res));

    assign fp_wrapped  = r_fp - (34'd1 << 32);
    assign pos_hi      = r_prod[45:32];
    assign idx_clamped = (32'(pos_hi) >= 32'(TABLE_SIZE)) ? TOP_IDX : pos_hi[TW-1:0];
    assign v_diff      = (r_v2 >= r_v1) ? (r_v2 - r_v1) : (r_v1 - r_v2);
    assign step        = r_prod[65:32];
    assign out_free    = !r_ovalid || o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            vosc_pkg::S_CLR: begin
                if (32'(r_clr_cnt) == 32'(CHANNELS - 1)) n_state = vosc_pkg::S_IDLE;
            end
            vosc_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.command == vosc_pkg::CMD_RESET) n_state = vosc_pkg::S_CLR;
                    else if (in_ch_ok)                       n_state = vosc_pkg::S_FETCH;
                end
            end
            vosc_pkg::S_FETCH:  n_state = vosc_pkg::S_MULC;
            vosc_pkg::S_MULC:   n_state = vosc_pkg::S_BRANCH;
            vosc_pkg::S_BRANCH: begin
                if (r_fp[PW-1:32] != 2'b00)      n_state = vosc_pkg::S_POS;
                else if (r_pp[PW-1:32] != 2'b00) n_state = (sat_inc == '0) ?
                                                     vosc_pkg::S_LIM : vosc_pkg::S_DIVR;
                else                             n_state = vosc_pkg::S_POS;
            end
            vosc_pkg::S_DIVR: if (div_done) n_state = vosc_pkg::S_LIM;
            vosc_pkg::S_LIM:  n_state = vosc_pkg::S_GAIN;
            vosc_pkg::S_GAIN: begin
                if (r_lim <= 0)          n_state = vosc_pkg::S_POS;
                else if (r_ratio == '0)  n_state = vosc_pkg::S_GMUL;
                else                     n_state = vosc_pkg::S_DIVF;
            end
            vosc_pkg::S_DIVF:   if (div_done) n_state = vosc_pkg::S_GMUL;
            vosc_pkg::S_GMUL:   n_state = vosc_pkg::S_GSET;
            vosc_pkg::S_GSET:   n_state = vosc_pkg::S_POS;
            vosc_pkg::S_POS:    n_state = vosc_pkg::S_IDX;
            vosc_pkg::S_IDX:    n_state = vosc_pkg::S_RD1;
            vosc_pkg::S_RD1:    n_state = vosc_pkg::S_RD2;
            vosc_pkg::S_RD2:    n_state = vosc_pkg::S_INTERP;
            vosc_pkg::S_INTERP: n_state = vosc_pkg::S_VAL;
            vosc_pkg::S_VAL:    n_state = vosc_pkg::S_OMUL;
            vosc_pkg::S_OMUL:   n_state = vosc_pkg::S_WB;
            vosc_pkg::S_WB:     if (out_free) n_state = vosc_pkg::S_IDLE;
            default:            n_state = vosc_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs: ready, multiplier operands, divider start, write
    always_comb begin
        i_in.ready       = (r_state == vosc_pkg::S_IDLE);
        mul_a            = '0;
        mul_b            = '0;
        div_req.start    = 1'b0;
        div_req.dividend = {r_finc, 31'd0};
        div_req.divisor  = r_cinc;
        mem_we           = 1'b0;
        mem_waddr        = CH_W'(r_ch);
        mem_wdata        = {(r_fp + 34'(r_finc)), (r_pp + 34'(r_cinc)), r_res, r_dec};
        case (r_state)
            vosc_pkg::S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_cnt;
                mem_wdata = {{(2 * PW + RW){1'b0}},
                             (r_clr_one ? vosc_pkg::GAIN_ONE : {GW{1'b0}})};
            end
            vosc_pkg::S_FETCH: begin
                mul_a = 34'(r_f);
                mul_b = r_sp;
            end
            vosc_pkg::S_MULC: begin
                mul_a = 34'(r_c);
                mul_b = r_sp;
            end
            vosc_pkg::S_BRANCH: begin
                div_req.start    = (r_fp[PW-1:32] == 2'b00) && (r_pp[PW-1:32] != 2'b00)
                                   && (sat_inc != '0);
                div_req.dividend = {r_finc, 31'd0};
                div_req.divisor  = sat_inc;
            end
            vosc_pkg::S_LIM: begin
                mul_a = 34'(r_dec);
                mul_b = (r_decay > vosc_pkg::GAIN_ONE) ? 32'(vosc_pkg::GAIN_ONE) : 32'(r_decay);
            end
            vosc_pkg::S_GAIN: begin
                div_req.start    = (r_lim > 0) && (r_ratio != '0);
                div_req.dividend = 64'(r_lim[35:0]) << 15;
                div_req.divisor  = 33'(r_ratio);
            end
            vosc_pkg::S_GMUL: begin
                mul_a = 34'(r_g);
                mul_b = 32'(r_fade);
            end
            vosc_pkg::S_POS: begin
                mul_a = r_pp;
                mul_b = 32'(TABLE_SIZE - 1);
            end
            vosc_pkg::S_INTERP: begin
                mul_a = 34'(r_frac);
                mul_b = 32'(v_diff);
            end
            vosc_pkg::S_OMUL, vosc_pkg::S_WB: begin
                mul_a = 34'(r_val);
                mul_b = 32'(r_dec);
            end
            default: ;
        endcase
        if ((r_state == vosc_pkg::S_WB) && out_free) mem_we = 1'b1;
    end

    // channel memory: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_mem_q <= mem[CH_W'(r_ch)];
    end

    // multiplier with registered product
    always_ff @(posedge i_clk) begin
        r_prod <= 66'(mul_a) * 66'(mul_b);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= vosc_pkg::S_CLR;
            r_clr_cnt <= '0;
            r_clr_one <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == vosc_pkg::S_CLR) r_clr_cnt <= r_clr_cnt + 1'b1;
            if ((r_state == vosc_pkg::S_IDLE) && i_in.valid
                && (i_in.command == vosc_pkg::CMD_RESET)) begin
                r_clr_cnt <= '0;
                r_clr_one <= 1'b1;
            end
            if ((r_state == vosc_pkg::S_WB) && out_free) r_ovalid <= 1'b1;
            else if (o_out.ready)                        r_ovalid <= 1'b0;
        end
    end

    // datapath registers, advanced by the sequencer
    always_ff @(posedge i_clk) begin
        case (r_state)
            vosc_pkg::S_IDLE: begin
                r_ch <= i_in.channel;
                r_f  <= in_f;
                r_c  <= in_c;
            end
            vosc_pkg::S_MULC: begin
                r_finc <= sat_inc;
                r_fp   <= r_mem_q[MEM_W-1 -: PW];
                r_pp   <= r_mem_q[MEM_W-PW-1 -: PW];
                r_res  <= r_mem_q[GW+RW-1 -: RW];
                r_dec  <= r_mem_q[GW-1:0];
            end
            vosc_pkg::S_BRANCH: begin
                r_cinc  <= sat_inc;
                r_ratio <= '0;
                if (r_fp[PW-1:32] != 2'b00) begin
                    // fundamental wrap: restart the pulse train at full gain
                    r_dec <= vosc_pkg::GAIN_ONE;
                    r_fp  <= fp_wrapped;
                    r_res <= fp_wrapped[31:0];
                    r_pp  <= '0;
                end else if (r_pp[PW-1:32] != 2'b00) begin
                    r_pp <= r_pp - (34'd1 << 32);
                end
            end
            vosc_pkg::S_DIVR: if (div_done) r_ratio <= div_quot[31:0];
            vosc_pkg::S_LIM:  r_lim <= lim_calc;
            vosc_pkg::S_GAIN: begin
                if (r_lim <= 0) r_dec <= '0;
                r_g    <= r_prod[32:16];
                r_fade <= vosc_pkg::GAIN_ONE;
            end
            vosc_pkg::S_DIVF: begin
                if (div_done) begin
                    r_fade <= (div_quot > 64'(vosc_pkg::GAIN_ONE)) ?
                              vosc_pkg::GAIN_ONE : div_quot[GW-1:0];
                end
            end
            vosc_pkg::S_GSET: r_dec <= r_prod[32:16];
            vosc_pkg::S_IDX: begin
                r_addr <= idx_clamped;
                r_frac <= r_prod[31:0];
            end
            vosc_pkg::S_RD1: begin
                r_v1   <= rom_data;
                r_addr <= (r_addr == TOP_IDX) ? '0 : r_addr + 1'b1;
            end
            vosc_pkg::S_RD2: r_v2 <= rom_data;
            vosc_pkg::S_VAL: begin
                r_val <= (r_v2 >= r_v1) ? (r_v1 + VW'(step)) : (r_v1 - VW'(step));
            end
            vosc_pkg::S_WB: begin
                if (out_free) begin
                    r_och     <= r_ch;
                    r_osample <= r_prod[46:31];
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.out_channel = r_och;
    assign o_out.sample_out  = r_osample;

endmodule

// ===== bench/tb_vosim_oscillator.sv =====
`timescale 1ns / 1ps
// Self-checking bench for vosim_oscillator: drives sample and reset-all requests,
// predicts each channel's phase/gain evolution and checks every output sample.
// Depends on vosc_pkg, vosc_in_if, vosc_out_if and the RTL top.
module tb_vosim_oscillator;

    localparam int NCH      = 16;
    localparam int TBL      = 512;
    localparam longint LIMIT = 4000000;

    typedef struct packed {
        logic                            command;
        logic [vosc_pkg::CH_FIELD_W-1:0] channel;
        logic [vosc_pkg::HZ_W-1:0]       fund_hz;
        logic [vosc_pkg::HZ_W-1:0]       center_hz;
    } t_req;

    typedef struct packed {
        logic [vosc_pkg::CH_FIELD_W-1:0] channel;
        logic [vosc_pkg::OUT_W-1:0]      sample;
    } t_smp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [vosc_pkg::ADDR_W-1:0] paddr = '0;
    logic [vosc_pkg::DATA_W-1:0] pwdata = '0;
    logic [vosc_pkg::DATA_W-1:0] prdata;
    logic pready;

    vosc_in_if  req_if ();
    vosc_out_if smp_if ();

    vosim_oscillator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(req_if.sink), .o_out(smp_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [30:0] sq_rom [TBL];
    logic [31:0] m_period;
    logic [16:0] m_decay, m_duty;
    logic [33:0] m_fph [NCH];
    logic [33:0] m_pph [NCH];
    logic [31:0] m_res [NCH];
    logic [16:0] m_gain [NCH];

    t_req pending_reqs[$];
    t_smp expected_smps[$];
    int   errors = 0;
    int   n_sent = 0, n_checked = 0;
    longint cycles = 0;
    int   send_idle_pct = 0, recv_stall_pct = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_vosim_oscillator NOT OK");
            $finish;
        end
    end

    // Build the sine-squared table from its own series evaluation.
    task automatic build_table();
        logic [63:0] x, term, s;
        longint sum;
        int j;
        for (int i = 0; i < TBL; i++) begin
            j = (i < TBL - 1 - i) ? i : TBL - 1 - i;
            x = (64'd3373259426 * 64'(j)) / 64'(TBL - 1);
            term = x;
            sum = longint'(x);
            for (int k = 1; k <= 6; k++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) sum = sum - longint'(term);
                else sum = sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            if (sum > 64'sd1073741824) sum = 1073741824;
            s = 64'(sum);
            sq_rom[i] = 31'((s * s) >> 30);
        end
    endtask

    function automatic logic [63:0] phase_step(input logic [63:0] hz);
        logic [63:0] inc;
        inc = (hz * {32'd0, m_period}) >> 8;
        return (inc > 64'h1_0000_0000) ? 64'h1_0000_0000 : inc;
    endfunction

    function automatic logic [63:0] table_lookup(input logic [33:0] ph);
        logic [63:0] pos, idx, frac, nxt, v1, v2;
        pos = {30'd0, ph} * 64'(TBL - 1);
        idx = pos >> 32;
        frac = pos & 64'hFFFF_FFFF;
        if (idx >= TBL) idx = TBL - 1;
        nxt = (idx + 1 >= TBL) ? 0 : idx + 1;
        v1 = sq_rom[idx];
        v2 = sq_rom[nxt];
        if (v2 >= v1) return v1 + ((frac * (v2 - v1)) >> 32);
        return v1 - ((frac * (v1 - v2)) >> 32);
    endfunction

    // Advance the oscillator model for one accepted request.
    task automatic advance_voice(input t_req r);
        longint f, c, lim, dl;
        logic [63:0] finc, cinc, ratio, d, g, fade, v;
        int ch;
        t_smp e;
        if (r.command == vosc_pkg::CMD_RESET) begin
            for (int i = 0; i < NCH; i++) begin
                m_fph[i] = '0; m_pph[i] = '0; m_res[i] = '0;
                m_gain[i] = vosc_pkg::GAIN_ONE;
            end
            return;
        end
        ch = r.channel;
        f = longint'($signed(r.fund_hz));
        c = longint'($signed(r.center_hz));
        if (f < 0) f = 0;
        if (c < f) c = f;
        finc = phase_step(64'(f));
        cinc = phase_step(64'(c));
        if (m_fph[ch] >= 34'h1_0000_0000) begin
            m_gain[ch] = vosc_pkg::GAIN_ONE;
            m_fph[ch] = m_fph[ch] - 34'h1_0000_0000;
            m_res[ch] = m_fph[ch][31:0];
            m_pph[ch] = '0;
        end else if (m_pph[ch] >= 34'h1_0000_0000) begin
            m_pph[ch] = m_pph[ch] - 34'h1_0000_0000;
            ratio = (cinc == 0) ? 0 : (finc << 31) / cinc;
            lim = 64'sh1_0000_0000 - longint'(ratio * 2);
            dl = longint'({47'd0, m_duty} << 16);
            if (dl < lim) lim = dl;
            lim = lim - longint'({30'd0, m_fph[ch]}) + longint'({32'd0, m_res[ch]});
            if (lim <= 0) begin
                m_gain[ch] = '0;
            end else begin
                d = (m_decay > vosc_pkg::GAIN_ONE) ? 64'd65536 : 64'(m_decay);
                g = (64'(m_gain[ch]) * d) >> 16;
                fade = 65536;
                if (ratio != 0) begin
                    fade = (64'(lim) << 15) / ratio;
                    if (fade > 65536) fade = 65536;
                end
                m_gain[ch] = 17'((g * fade) >> 16);
            end
        end
        v = table_lookup(m_pph[ch]);
        e.channel = r.channel;
        e.sample = 16'((v * 64'(m_gain[ch])) >> 31);
        expected_smps.push_back(e);
        m_fph[ch] = m_fph[ch] + 34'(finc);
        m_pph[ch] = m_pph[ch] + 34'(cinc);
    endtask

    task automatic report_mismatch(input string what, input t_smp got, input t_smp want);
        errors++;
        $display("mismatch %s at cycle %0d: got ch %0d smp %0d, want ch %0d smp %0d",
                 what, cycles, got.channel, got.sample, want.channel, want.sample);
    endtask

    // Driver: present pending requests, idle at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (req_if.valid) begin
                advance_voice(t_req'({req_if.command, req_if.channel,
                                      req_if.fund_hz, req_if.center_hz}));
                n_sent++;
                void'(pending_reqs.pop_front());
            end
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                req_if.valid     <= 1'b1;
                req_if.command   <= pending_reqs[0].command;
                req_if.channel   <= pending_reqs[0].channel;
                req_if.fund_hz   <= pending_reqs[0].fund_hz;
                req_if.center_hz <= pending_reqs[0].center_hz;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: check each output transfer, stall at random.
    always @(posedge i_clk) begin
        t_smp got, want;
        if (i_rst_n && smp_if.valid && smp_if.ready) begin
            got.channel = smp_if.out_channel;
            got.sample  = smp_if.sample_out;
            if (expected_smps.size() == 0) begin
                want = '0;
                report_mismatch("unexpected", got, want);
            end else begin
                want = expected_smps.pop_front();
                n_checked++;
                if (got.channel != want.channel) report_mismatch("channel", got, want);
                else if (got.sample != want.sample) report_mismatch("sample", got, want);
            end
        end
        smp_if.ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Setup phase, access phase, then the port returns to idle.
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            vosc_pkg::REG_SAMPLE_PERIOD: m_period = val;
            vosc_pkg::REG_DECAY_GAIN:    m_decay = val[16:0];
            default:                     m_duty = val[16:0];
        endcase
        @(posedge i_clk);
    endtask

    // Wait until every queued request has gone and all samples are back.
    task automatic drain();
        while (pending_reqs.size() > 0 || req_if.valid || expected_smps.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic t_req mk(input logic cmd, input int ch, input int fh, input int ch2);
        t_req r;
        r.command = cmd; r.channel = ch[3:0];
        r.fund_hz = fh[23:0]; r.center_hz = ch2[23:0];
        return r;
    endfunction

    // Mostly audio-range voices: fundamental below center, occasional resets and noise.
    task automatic queue_voices(input int n);
        int fh, cf, kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(99);
            if (kind < 3) begin
                pending_reqs.push_back(mk(vosc_pkg::CMD_RESET, $urandom_range(15),
                                          $urandom, $urandom));
            end else if (kind < 15) begin
                pending_reqs.push_back(mk(vosc_pkg::CMD_SAMPLE, $urandom_range(15),
                                          $urandom, $urandom));
            end else begin
                fh = $urandom_range(1000 * 256, 20 * 256);
                cf = fh * $urandom_range(12, 2) + $urandom_range(255);
                if (cf > 8388607) cf = 8388607;
                pending_reqs.push_back(mk(vosc_pkg::CMD_SAMPLE, $urandom_range(3), fh, cf));
            end
        end
    endtask

    initial begin
        int phase_pct [4][2] = '{'{0, 0}, '{67, 0}, '{0, 67}, '{19, 19}};
        req_if.valid = 1'b0; req_if.command = vosc_pkg::CMD_SAMPLE; req_if.channel = '0;
        req_if.fund_hz = '0; req_if.center_hz = '0;
        smp_if.ready = 1'b0;
        m_period = '0; m_decay = '0; m_duty = vosc_pkg::GAIN_ONE;
        for (int i = 0; i < NCH; i++) begin
            m_fph[i] = '0; m_pph[i] = '0; m_res[i] = '0; m_gain[i] = '0;
        end
        build_table();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // defaults: zero period, zero gains until a reset command
        pending_reqs.push_back(mk(vosc_pkg::CMD_SAMPLE, 15, 8388607, -8388608));
        pending_reqs.push_back(mk(vosc_pkg::CMD_SAMPLE, 0, -8388608, 8388607));
        drain();
        // 1/48000 Q0.32, unity decay
        reg_write(vosc_pkg::REG_SAMPLE_PERIOD, 32'd89478);
        reg_write(vosc_pkg::REG_DECAY_GAIN, 32'd65536);
        reg_write(vosc_pkg::REG_DUTY_LIMIT, 32'd65536);
        pending_reqs.push_back(mk(vosc_pkg::CMD_RESET, 0, 0, 0));
        pending_reqs.push_back(mk(vosc_pkg::CMD_SAMPLE, 0, 0, 0));
        pending_reqs.push_back(mk(vosc_pkg::CMD_SAMPLE, 1, -256, 1000 * 256));
        pending_reqs.push_back(mk(vosc_pkg::CMD_SAMPLE, 2, 8388607, 8388607));
        pending_reqs.push_back(mk(vosc_pkg::CMD_SAMPLE, 2, 8388607, -8388608));
        pending_reqs.push_back(mk(vosc_pkg::CMD_SAMPLE, 3, 440 * 256, 100 * 256));
        for (int i = 0; i < 12; i++)
            pending_reqs.push_back(mk(vosc_pkg::CMD_SAMPLE, 4, 3000 * 256, 12000 * 256 + i));
        drain();
        // extreme period saturates both increments
        reg_write(vosc_pkg::REG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
        reg_write(vosc_pkg::REG_DECAY_GAIN, 32'd131071);
        reg_write(vosc_pkg::REG_DUTY_LIMIT, 32'd131071);
        for (int i = 0; i < 6; i++)
            pending_reqs.push_back(mk(vosc_pkg::CMD_SAMPLE, 5, 8388607, 8388607));
        drain();
        // random phases over several register settings and idling mixes
        for (int p = 0; p < 8; p++) begin
            send_idle_pct  = phase_pct[p % 4][0];
            recv_stall_pct = phase_pct[p % 4][1];
            reg_write(vosc_pkg::REG_SAMPLE_PERIOD,
                      (p == 6) ? $urandom : $urandom_range(400000, 40000));
            reg_write(vosc_pkg::REG_DECAY_GAIN,
                      (p == 3) ? 32'd0 : $urandom_range(65536, 30000));
            reg_write(vosc_pkg::REG_DUTY_LIMIT, (p == 5) ? 32'd0 : $urandom_range(131071));
            pending_reqs.push_back(mk(vosc_pkg::CMD_RESET, 0, 0, 0));
            queue_voices(225);
            drain();
        end
        $display("covered %0d requests and %0d checked samples over 8 register settings",
                 n_sent, n_checked);
        $display("with reset-all commands, saturated increments and four idling mixes");
        if (errors == 0 && expected_smps.size() == 0) begin
            $display("tb_vosim_oscillator OK");
        end else begin
            $display("tb_vosim_oscillator NOT OK");
        end
        $finish;
    end
endmodule
